// ===== sv/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 step for the humidity/temperature frame decoder.
// Depends on nothing; imported by the decoder top level and its port checker.
`timescale 1ns / 1ps

package htfd_pkg;

   localparam logic [7:0]  CRC_POLY = 8'h31;
   localparam logic [7:0]  CRC_INIT = 8'hFF;

   // Frame byte positions.
   localparam logic [2:0]  POS_TEMP_HI = 3'd0;
   localparam logic [2:0]  POS_TEMP_LO = 3'd1;
   localparam logic [2:0]  POS_TEMP_CRC = 3'd2;
   localparam logic [2:0]  POS_HUMI_HI = 3'd3;
   localparam logic [2:0]  POS_HUMI_LO = 3'd4;
   localparam logic [2:0]  POS_HUMI_CRC = 3'd5;

   // Conversion constants in hundredths.
   localparam int unsigned TEMP_SCALE = 17500;
   localparam int unsigned TEMP_OFFSET = 4500;
   localparam int unsigned HUMI_SCALE = 12500;
   localparam int unsigned HUMI_OFFSET = 600;
   localparam int unsigned HUMI_MAX = 10000;
   localparam int unsigned RAW_FULL = 65535;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [13:0]        humidity_centi;
      logic               temp_crc_ok;
      logic               humi_crc_ok;
      logic               frame_valid;
   } rsp_payload_type;

   // One byte through the CRC-8, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/humidity_temp_frame_decoder_unit.sv =====
// Humidity/temperature measurement frame decoder: CRC check and conversion to hundredths.
// Depends on htfd_pkg for payload types, constants and the CRC-8 step.
//
// Usage: the req_ channel carries one received frame byte per beat, in the order
// temperature high, low, CRC, humidity high, low, CRC. Setting frame_start on a
// beat makes that byte the first of a new frame and drops any partial frame.
// After the sixth byte one result beat leaves on the rsp_ channel with both
// converted values, the two CRC flags and their AND; frames may follow back to
// back without a start flag. Bad CRCs still yield a result, with the flags low.
// Latency: the result is valid the cycle after the sixth byte is accepted.
// Throughput: one byte per clock except while a waiting result holds the sixth
// byte; the conversion (one constant multiply and a single-step correction for
// the divide by 65535) sits between the frame and result registers, so nothing iterates.
// Reset (synchronous, active high) returns to the start of a frame with an
// empty result register. While a result waits on a stalled receiver, bytes
// before the sixth position are still taken; any byte offered at the sixth
// position waits, even one that carries a start flag.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  htfd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output htfd_pkg::rsp_payload_type rsp_payload
);
   import htfd_pkg::*;

   logic [2:0]      byte_pos_ff, byte_pos_in;
   logic [7:0]      crc_ff, crc_in;
   logic [15:0]     raw_temp_ff, raw_temp_in;
   logic [15:0]     raw_humi_ff, raw_humi_in;
   logic            temp_ok_ff, temp_ok_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            accept;
   logic            restart;
   logic [2:0]      pos_eff;
   logic [7:0]      crc_base;
   logic [7:0]      crc_next;
   logic            emit;
   logic            humi_ok;

   logic [30:0]     temp_prod;
   logic [14:0]     temp_q0;
   logic [16:0]     temp_rem;
   logic [14:0]     temp_q;
   logic signed [15:0] temp_wide;
   logic [29:0]     humi_prod;
   logic [13:0]     humi_q0;
   logic [16:0]     humi_rem;
   logic [13:0]     humi_q;
   logic [13:0]     humi_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready || (byte_pos_ff != POS_HUMI_CRC);

   assign restart  = req_payload.frame_start || (byte_pos_ff > POS_HUMI_CRC);
   assign pos_eff  = restart ? POS_TEMP_HI : byte_pos_ff;
   assign crc_base = restart ? CRC_INIT : crc_ff;
   assign crc_next = crc8_byte(crc_base, req_payload.rx_byte);
   assign humi_ok  = (crc_base == req_payload.rx_byte);

   always_comb begin
      byte_pos_in = byte_pos_ff;
      crc_in      = crc_ff;
      raw_temp_in = raw_temp_ff;
      raw_humi_in = raw_humi_ff;
      temp_ok_in  = temp_ok_ff;
      emit        = 1'b0;
      if (accept) begin
         unique case (pos_eff)
            POS_TEMP_HI: begin
               crc_in      = crc_next;
               raw_temp_in = {req_payload.rx_byte, raw_temp_ff[7:0]};
               byte_pos_in = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
               crc_in      = crc_next;
               raw_temp_in = {raw_temp_ff[15:8], req_payload.rx_byte};
               byte_pos_in = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
               temp_ok_in  = (crc_base == req_payload.rx_byte);
               crc_in      = CRC_INIT;
               byte_pos_in = POS_HUMI_HI;
            end
            POS_HUMI_HI: begin
               crc_in      = crc_next;
               raw_humi_in = {req_payload.rx_byte, raw_humi_ff[7:0]};
               byte_pos_in = POS_HUMI_LO;
            end
            POS_HUMI_LO: begin
               crc_in      = crc_next;
               raw_humi_in = {raw_humi_ff[15:8], req_payload.rx_byte};
               byte_pos_in = POS_HUMI_CRC;
            end
            default: begin
               crc_in      = CRC_INIT;
               byte_pos_in = POS_TEMP_HI;
               emit        = 1'b1;
            end
         endcase
      end
   end

   // Divide by 65535: with q0 = p >> 16 the remainder is p[15:0] + q0, which
   // stays below twice the divisor, so one compare fixes the quotient.
   always_comb begin
      temp_prod = 31'(raw_temp_ff) * 31'(TEMP_SCALE);
      temp_q0   = temp_prod[30:16];
      temp_rem  = 17'(temp_prod[15:0]) + 17'(temp_q0);
      temp_q    = temp_q0 + 15'(temp_rem >= 17'(RAW_FULL));
      temp_wide = $signed({1'b0, temp_q}) - $signed(16'(TEMP_OFFSET));

      humi_prod = 30'(raw_humi_ff) * 30'(HUMI_SCALE);
      humi_q0   = humi_prod[29:16];
      humi_rem  = 17'(humi_prod[15:0]) + 17'(humi_q0);
      humi_q    = humi_q0 + 14'(humi_rem >= 17'(RAW_FULL));
      priority if (humi_q < 14'(HUMI_OFFSET)) begin
         humi_sat = '0;
      end else if (humi_q > 14'(HUMI_MAX + HUMI_OFFSET)) begin
         humi_sat = 14'(HUMI_MAX);
      end else begin
         humi_sat = humi_q - 14'(HUMI_OFFSET);
      end
   end

   always_comb begin
      rsp_payload_in                   = rsp_payload_ff;
      rsp_valid_in                     = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in                     = 1'b1;
         rsp_payload_in.temperature_centi = temp_wide[14:0];
         rsp_payload_in.humidity_centi    = humi_sat;
         rsp_payload_in.temp_crc_ok       = temp_ok_ff;
         rsp_payload_in.humi_crc_ok       = humi_ok;
         rsp_payload_in.frame_valid       = temp_ok_ff && humi_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= POS_TEMP_HI;
         crc_ff       <= CRC_INIT;
         raw_temp_ff  <= '0;
         raw_humi_ff  <= '0;
         temp_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         crc_ff       <= crc_in;
         raw_temp_ff  <= raw_temp_in;
         raw_humi_ff  <= raw_humi_in;
         temp_ok_ff   <= temp_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sv/htfd_checker.sv =====
// Port-level checker for the humidity/temperature frame decoder, bound to its top level.
// Depends on htfd_pkg for the payload types and conversion limits.
`timescale 1ns / 1ps

module htfd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input htfd_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input htfd_pkg::rsp_payload_type rsp_payload
);
   import htfd_pkg::*;

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // A new result only follows an accepted input byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result beat without an accepted byte");

   a_valid_and: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.frame_valid ==
                    (rsp_payload.temp_crc_ok && rsp_payload.humi_crc_ok))
      else $error("frame_valid disagrees with the CRC flags");

   a_humi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.humidity_centi <= 14'(HUMI_MAX))
      else $error("humidity out of range");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.temperature_centi >= -15'sd4500 &&
                    rsp_payload.temperature_centi <= 15'sd13000)
      else $error("temperature out of range");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
